[src/scgb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package scgb_pkg;

    // field and register widths
    localparam int COORD_W   = 16;
    localparam int PIX_W     = 12;
    localparam int OFS_W     = 26;
    localparam int VAL_W     = 32;
    localparam int COLOR_W   = 24;
    localparam int CFG_W     = 24;
    localparam int CFG_IDX_W = 3;
    localparam int FMT_W     = 1;
    localparam int MASK_W    = 4;
    localparam int GLYPH_W   = 6;
    localparam int ZOOM_IN_W = 8;
    localparam int PLANE_W   = 2;

    // zoom range and the rows of one scaled pixel
    localparam int MAX_ZOOM = 4;
    localparam int ZOOM_W   = $clog2(MAX_ZOOM + 1);
    localparam int ROWS     = MAX_ZOOM;
    localparam int DY_W     = $clog2(ROWS);

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PLANE_MASK   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_INK_COLOR    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_SHADE_COLOR  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_ACCENT_COLOR = 3'd6;

    // register reset values
    localparam logic [PIX_W-1:0]   RST_FRAME_WIDTH  = 12'd320;
    localparam logic [PIX_W-1:0]   RST_FRAME_HEIGHT = 12'd240;
    localparam logic [FMT_W-1:0]   RST_PIXEL_FORMAT = 1'b0;
    localparam logic [MASK_W-1:0]  RST_PLANE_MASK   = 4'he;
    localparam logic [COLOR_W-1:0] RST_INK_COLOR    = 24'hffffff;
    localparam logic [COLOR_W-1:0] RST_SHADE_COLOR  = 24'ha0a0a0;
    localparam logic [COLOR_W-1:0] RST_ACCENT_COLOR = 24'hffffff;

    // pixel formats
    localparam logic [FMT_W-1:0] FMT_RGB565   = 1'b0;
    localparam logic [FMT_W-1:0] FMT_RGBA8888 = 1'b1;

    // palette planes
    localparam logic [PLANE_W-1:0] PLANE_CLEAR  = 2'd0;
    localparam logic [PLANE_W-1:0] PLANE_INK    = 2'd1;
    localparam logic [PLANE_W-1:0] PLANE_SHADE  = 2'd2;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hff;

    // one scaled glyph pixel, ready to walk
    typedef struct packed {
        logic [PIX_W-1:0]  x0;
        logic [PIX_W-1:0]  x1;
        logic [PIX_W-1:0]  ybase;
        logic [ROWS-1:0]   rows;
        logic [VAL_W-1:0]  value;
        logic              wide;
    } walk_t;

    // pack a 24-bit color into the surface format
    function automatic logic [VAL_W-1:0] encode_color(
        input logic [COLOR_W-1:0] rgb,
        input logic [FMT_W-1:0]   fmt
    );
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        r = rgb[23:16];
        g = rgb[15:8];
        b = rgb[7:0];
        if (fmt == FMT_RGB565)
        begin
            return {16'h0000, r[7:3], g[7:2], b[7:3]};
        end
        return {ALPHA_OPAQUE, b, g, r};
    endfunction

    // index of the lowest set row
    function automatic logic [DY_W-1:0] lowest_row(input logic [ROWS-1:0] m);
        logic [DY_W-1:0] r;
        r = '0;
        for (int i = ROWS - 1; i >= 0; i--)
        begin
            if (m[i])
            begin
                r = DY_W'(i);
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[src/scaled_glyph_pixel_blitter.sv]
`timescale 1ns / 1ps
`default_nettype none

// Expands one decoded glyph pixel into a clipped square of framebuffer writes.
// An item that draws nothing (clear or masked plane, or fully clipped) gives
// no writes; a drawn item gives one write per pixel that survives clipping,
// at most zoom*zoom, so up to 16 writes at zoom 4. The write walker emits one
// write a cycle and takes the next item in the same cycle as the last write of
// the current one. Writes come row by row, left to right, with last set on the
// final one. Results leave through an output register, and the walker stalls
// while a write waits there to be taken; the byte offset comes from one
// 12x12 multiply in front of that register. Configuration is sampled at
// accept, except the frame width, which is read as each offset is formed, so
// it must only change while the block is idle.
module scaled_glyph_pixel_blitter (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   cfg_write,
    input  logic [scgb_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [scgb_pkg::CFG_W-1:0]             cfg_data,
    input  logic                                   in_valid,
    output logic                                   in_ready,
    input  logic signed [scgb_pkg::COORD_W-1:0]    glyph_left,
    input  logic signed [scgb_pkg::COORD_W-1:0]    glyph_top,
    input  logic [scgb_pkg::GLYPH_W-1:0]           column,
    input  logic [scgb_pkg::GLYPH_W-1:0]           row_index,
    input  logic [scgb_pkg::ZOOM_IN_W-1:0]         zoom,
    input  logic [scgb_pkg::PLANE_W-1:0]           plane,
    output logic                                   out_valid,
    input  logic                                   out_ready,
    output logic [scgb_pkg::PIX_W-1:0]             pixel_x,
    output logic [scgb_pkg::PIX_W-1:0]             pixel_y,
    output logic [scgb_pkg::OFS_W-1:0]             byte_offset,
    output logic [scgb_pkg::VAL_W-1:0]             pixel_value,
    output logic                                   last
);
    import scgb_pkg::*;

    localparam int OFF_W = GLYPH_W + ZOOM_W;
    localparam int LIN_W = 2 * PIX_W + 1;

    logic [PIX_W-1:0]   frame_width_reg;
    logic [PIX_W-1:0]   frame_height_reg;
    logic [FMT_W-1:0]   pixel_format_reg;
    logic [MASK_W-1:0]  plane_mask_reg;
    logic [COLOR_W-1:0] ink_color_reg;
    logic [COLOR_W-1:0] shade_color_reg;
    logic [COLOR_W-1:0] accent_color_reg;

    logic [ZOOM_W-1:0]  zoom_c;
    logic [OFF_W-1:0]   col_off;
    logic [OFF_W-1:0]   row_off;
    logic [COORD_W-1:0] x_start;
    logic [COORD_W-1:0] x_end;
    logic [COORD_W-1:0] x_lo;
    logic [COORD_W-1:0] x_hi;
    logic [COORD_W-1:0] y_start;
    logic [COORD_W-1:0] y_row [ROWS];
    logic [ROWS-1:0]    rows_ok;
    logic               x_ok;
    logic               plane_ok;
    logic               draws;
    logic [COLOR_W-1:0] color_sel;
    walk_t              desc;

    logic               walk_valid_reg;
    logic               walk_valid_next;
    walk_t              walk_reg;
    walk_t              walk_next;
    logic [PIX_W-1:0]   cur_x_reg;
    logic [PIX_W-1:0]   cur_x_next;
    logic [DY_W-1:0]    cur_dy_reg;
    logic [DY_W-1:0]    cur_dy_next;
    logic [ROWS-1:0]    rows_above;
    logic               row_end;
    logic               item_done;
    logic               step;
    logic               in_fire;
    logic               load;

    logic [PIX_W-1:0]   py;
    logic [2*PIX_W-1:0] prod;
    logic [LIN_W-1:0]   lin;
    logic [OFS_W-1:0]   offset;

    logic               out_valid_reg;
    logic               out_valid_next;
    logic [PIX_W-1:0]   pixel_x_reg;
    logic [PIX_W-1:0]   pixel_y_reg;
    logic [OFS_W-1:0]   byte_offset_reg;
    logic [VAL_W-1:0]   pixel_value_reg;
    logic               last_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            pixel_format_reg <= RST_PIXEL_FORMAT;
            plane_mask_reg   <= RST_PLANE_MASK;
            ink_color_reg    <= RST_INK_COLOR;
            shade_color_reg  <= RST_SHADE_COLOR;
            accent_color_reg <= RST_ACCENT_COLOR;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_data[PIX_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_data[PIX_W-1:0];
                REG_PIXEL_FORMAT: pixel_format_reg <= cfg_data[FMT_W-1:0];
                REG_PLANE_MASK:   plane_mask_reg   <= cfg_data[MASK_W-1:0];
                REG_INK_COLOR:    ink_color_reg    <= cfg_data[COLOR_W-1:0];
                REG_SHADE_COLOR:  shade_color_reg  <= cfg_data[COLOR_W-1:0];
                REG_ACCENT_COLOR: accent_color_reg <= cfg_data[COLOR_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // clamp zoom and place the scaled pixel, with 16-bit wrap
    always_comb
    begin
        if (zoom == '0)
        begin
            zoom_c = ZOOM_W'(1);
        end
        else if (zoom > ZOOM_IN_W'(MAX_ZOOM))
        begin
            zoom_c = ZOOM_W'(MAX_ZOOM);
        end
        else
        begin
            zoom_c = zoom[ZOOM_W-1:0];
        end
        col_off = OFF_W'(column) * OFF_W'(zoom_c);
        row_off = OFF_W'(row_index) * OFF_W'(zoom_c);
        x_start = COORD_W'(glyph_left) + COORD_W'(col_off);
        x_end   = x_start + COORD_W'(zoom_c);
        y_start = COORD_W'(glyph_top) + COORD_W'(row_off);
    end

    // horizontal clip
    always_comb
    begin
        x_lo = x_start[COORD_W-1] ? '0 : x_start;
        if (x_end > COORD_W'(frame_width_reg))
        begin
            x_hi = COORD_W'(frame_width_reg);
        end
        else
        begin
            x_hi = x_end;
        end
        x_ok = !x_end[COORD_W-1] && (x_lo < x_hi);
    end

    // vertical clip, one bit per row of the square
    always_comb
    begin
        for (int dy = 0; dy < ROWS; dy++)
        begin
            y_row[dy] = y_start + COORD_W'(dy);
            rows_ok[dy] = (ZOOM_W'(dy) < zoom_c) && !y_row[dy][COORD_W-1]
                && (y_row[dy] < COORD_W'(frame_height_reg));
        end
    end

    // plane test and color
    always_comb
    begin
        plane_ok = (plane != PLANE_CLEAR) && plane_mask_reg[plane];
        case (plane)
            PLANE_INK:   color_sel = ink_color_reg;
            PLANE_SHADE: color_sel = shade_color_reg;
            default:     color_sel = accent_color_reg;
        endcase
        desc.x0    = x_lo[PIX_W-1:0];
        desc.x1    = x_hi[PIX_W-1:0];
        desc.ybase = y_start[PIX_W-1:0];
        desc.rows  = rows_ok;
        desc.value = encode_color(color_sel, pixel_format_reg);
        desc.wide  = (pixel_format_reg == FMT_RGBA8888);
        draws      = plane_ok && x_ok && (|rows_ok);
    end

    // walker handshake
    always_comb
    begin
        for (int i = 0; i < ROWS; i++)
        begin
            rows_above[i] = walk_reg.rows[i] && (DY_W'(i) > cur_dy_reg);
        end
        row_end   = (PIX_W'(cur_x_reg + PIX_W'(1)) == walk_reg.x1);
        item_done = row_end && !(|rows_above);
        step      = walk_valid_reg && (!out_valid_reg || out_ready);
        in_ready  = !walk_valid_reg || (step && item_done);
        in_fire   = in_valid && in_ready;
        load      = in_fire && draws;
    end

    // walker next state
    always_comb
    begin
        walk_valid_next = walk_valid_reg;
        walk_next       = walk_reg;
        cur_x_next      = cur_x_reg;
        cur_dy_next     = cur_dy_reg;
        if (load)
        begin
            walk_valid_next = 1'b1;
            walk_next       = desc;
            cur_x_next      = desc.x0;
            cur_dy_next     = lowest_row(desc.rows);
        end
        else if (step)
        begin
            if (item_done)
            begin
                walk_valid_next = 1'b0;
            end
            else if (row_end)
            begin
                cur_x_next  = walk_reg.x0;
                cur_dy_next = lowest_row(rows_above);
            end
            else
            begin
                cur_x_next = PIX_W'(cur_x_reg + PIX_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_valid_reg <= 1'b0;
        end
        else
        begin
            walk_valid_reg <= walk_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        walk_reg   <= walk_next;
        cur_x_reg  <= cur_x_next;
        cur_dy_reg <= cur_dy_next;
    end

    // byte offset of the current write
    always_comb
    begin
        py   = PIX_W'(walk_reg.ybase + PIX_W'(cur_dy_reg));
        prod = py * frame_width_reg;
        lin  = LIN_W'(prod) + LIN_W'(cur_x_reg);
        if (walk_reg.wide)
        begin
            offset = OFS_W'({lin, 2'b00});
        end
        else
        begin
            offset = OFS_W'({lin, 1'b0});
        end
    end

    // output register
    always_comb
    begin
        if (step)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            pixel_x_reg     <= cur_x_reg;
            pixel_y_reg     <= py;
            byte_offset_reg <= offset;
            pixel_value_reg <= walk_reg.value;
            last_reg        <= item_done;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_x     = pixel_x_reg;
    assign pixel_y     = pixel_y_reg;
    assign byte_offset = byte_offset_reg;
    assign pixel_value = pixel_value_reg;
    assign last        = last_reg;

`ifndef SYNTHESIS
    // walker column stays inside the clipped span
    a_x_in_span: assert property (@(posedge clk) disable iff (!rst_n)
        walk_valid_reg |-> (cur_x_reg >= walk_reg.x0) && (cur_x_reg < walk_reg.x1))
        else $error("walker column outside clipped span");

    // walker only visits rows that survived clipping
    a_row_live: assert property (@(posedge clk) disable iff (!rst_n)
        walk_valid_reg |-> walk_reg.rows[cur_dy_reg])
        else $error("walker on a clipped row");

    // the final write frees the walker unless a new item enters
    a_done_frees: assert property (@(posedge clk) disable iff (!rst_n)
        (step && item_done && !load) |=> !walk_valid_reg)
        else $error("walker busy after final write");

    // a drawn item starts at its left edge
    a_load_start: assert property (@(posedge clk) disable iff (!rst_n)
        load |=> walk_valid_reg && (cur_x_reg == walk_reg.x0))
        else $error("walker did not start at left edge");
`endif

endmodule

`default_nettype wire

[tb/scgb_blit_checker.sv]
`timescale 1ns / 1ps

// watches the pixel and write channels, predicts the framebuffer writes of
// every accepted glyph pixel and compares them in order
module scgb_blit_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write,
    input  logic [scgb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scgb_pkg::CFG_W-1:0]          cfg_data,
    input  logic                                in_valid,
    input  logic                                in_ready,
    input  logic signed [scgb_pkg::COORD_W-1:0] glyph_left,
    input  logic signed [scgb_pkg::COORD_W-1:0] glyph_top,
    input  logic [scgb_pkg::GLYPH_W-1:0]        column,
    input  logic [scgb_pkg::GLYPH_W-1:0]        row_index,
    input  logic [scgb_pkg::ZOOM_IN_W-1:0]      zoom,
    input  logic [scgb_pkg::PLANE_W-1:0]        plane,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [scgb_pkg::PIX_W-1:0]          pixel_x,
    input  logic [scgb_pkg::PIX_W-1:0]          pixel_y,
    input  logic [scgb_pkg::OFS_W-1:0]          byte_offset,
    input  logic [scgb_pkg::VAL_W-1:0]          pixel_value,
    input  logic                                last,
    output int                                  mismatch_count,
    output int                                  pending_writes
);

    import scgb_pkg::*;

    // one predicted framebuffer write
    typedef struct packed {
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] py;
        logic [OFS_W-1:0] ofs;
        logic [VAL_W-1:0] val;
        logic             lst;
    } fb_write_t;

    fb_write_t expected_writes[$];
    fb_write_t want;

    // shadow copy of the surface registers
    logic [PIX_W-1:0]   fb_width;
    logic [PIX_W-1:0]   fb_height;
    logic [FMT_W-1:0]   pix_fmt;
    logic [MASK_W-1:0]  plane_on;
    logic [COLOR_W-1:0] ink_rgb;
    logic [COLOR_W-1:0] shade_rgb;
    logic [COLOR_W-1:0] accent_rgb;

    // low 16 bits as a signed coordinate
    function automatic int to_s16(input int unsigned v);
        logic signed [15:0] t;
        t = v[15:0];
        return int'(t);
    endfunction

    // expand one glyph pixel into its clipped square of writes
    function automatic void predict_blit(
        input logic [COORD_W-1:0]   left,
        input logic [COORD_W-1:0]   top,
        input logic [GLYPH_W-1:0]   col,
        input logic [GLYPH_W-1:0]   row,
        input logic [ZOOM_IN_W-1:0] zin,
        input logic [PLANE_W-1:0]   pl
    );
        int unsigned        zc;
        int unsigned        bpp;
        int unsigned        stride;
        int unsigned        dy;
        int                 fw;
        int                 fh;
        int                 xs;
        int                 x0;
        int                 x1;
        int                 y;
        int                 px;
        logic [COLOR_W-1:0] rgb;
        logic [VAL_W-1:0]   val;
        fb_write_t          wr;
        bit                 have_wr;

        // zoom clamped to 1..MAX_ZOOM
        if (zin == '0)
            zc = 1;
        else if (32'(zin) > MAX_ZOOM)
            zc = MAX_ZOOM;
        else
            zc = 32'(zin);

        // transparent or masked plane draws nothing
        if (pl == PLANE_CLEAR || !plane_on[pl])
            return;

        case (pl)
            PLANE_INK:   rgb = ink_rgb;
            PLANE_SHADE: rgb = shade_rgb;
            default:     rgb = accent_rgb;
        endcase

        if (pix_fmt == FMT_RGB565)
        begin
            bpp = 2;
            val = {16'h0000, rgb[23:19], rgb[15:10], rgb[7:3]};
        end
        else
        begin
            bpp = 4;
            val = {ALPHA_OPAQUE, rgb[7:0], rgb[15:8], rgb[23:16]};
        end
        stride = 32'(fb_width) * bpp;
        fw = 32'(fb_width);
        fh = 32'(fb_height);

        // horizontal span, wrapped to 16 bits, then clipped
        xs = to_s16(32'(left) + 32'(col) * zc);
        x1 = to_s16($unsigned(xs) + zc);
        x0 = (xs < 0) ? 0 : xs;
        if (x1 > fw)
            x1 = fw;
        if (x0 >= x1)
            return;

        // rows outer, columns inner; the final write is held back to mark it
        have_wr = 1'b0;
        wr = '0;
        for (dy = 0; dy < zc; dy++)
        begin
            y = to_s16(32'(top) + 32'(row) * zc + dy);
            if (y < 0 || y >= fh)
                continue;
            for (px = x0; px < x1; px++)
            begin
                if (have_wr)
                    expected_writes.push_back(wr);
                wr.px  = PIX_W'(px);
                wr.py  = PIX_W'(y);
                wr.ofs = OFS_W'($unsigned(y) * stride + $unsigned(px) * bpp);
                wr.val = val;
                wr.lst = 1'b0;
                have_wr = 1'b1;
            end
        end
        if (have_wr)
        begin
            wr.lst = 1'b1;
            expected_writes.push_back(wr);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb_width   = RST_FRAME_WIDTH;
            fb_height  = RST_FRAME_HEIGHT;
            pix_fmt    = RST_PIXEL_FORMAT;
            plane_on   = RST_PLANE_MASK;
            ink_rgb    = RST_INK_COLOR;
            shade_rgb  = RST_SHADE_COLOR;
            accent_rgb = RST_ACCENT_COLOR;
            expected_writes.delete();
            mismatch_count = 0;
            pending_writes = 0;
        end
        else
        begin
            // write transfer against the oldest prediction
            if (out_valid && out_ready)
            begin
                if (expected_writes.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                    begin
                        $write("[%0t] unexpected write: ", $realtime);
                        $display("x=%0d y=%0d ofs=%0h val=%08h last=%0b",
                                 pixel_x, pixel_y, byte_offset, pixel_value, last);
                    end
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (pixel_x !== want.px || pixel_y !== want.py ||
                        byte_offset !== want.ofs || pixel_value !== want.val ||
                        last !== want.lst)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                        begin
                            $write("[%0t] write mismatch: exp x=%0d y=%0d ofs=%0h ",
                                   $realtime, want.px, want.py, want.ofs);
                            $write("val=%08h last=%0b, ", want.val, want.lst);
                            $display("got x=%0d y=%0d ofs=%0h val=%08h last=%0b",
                                     pixel_x, pixel_y, byte_offset, pixel_value, last);
                        end
                    end
                end
            end

            // pixel transfer uses the registers as they stood before this edge
            if (in_valid && in_ready)
                predict_blit(glyph_left, glyph_top, column, row_index, zoom, plane);

            // register writes
            if (cfg_write)
            begin
                case (cfg_index)
                    REG_FRAME_WIDTH:  fb_width   = cfg_data[PIX_W-1:0];
                    REG_FRAME_HEIGHT: fb_height  = cfg_data[PIX_W-1:0];
                    REG_PIXEL_FORMAT: pix_fmt    = cfg_data[FMT_W-1:0];
                    REG_PLANE_MASK:   plane_on   = cfg_data[MASK_W-1:0];
                    REG_INK_COLOR:    ink_rgb    = cfg_data[COLOR_W-1:0];
                    REG_SHADE_COLOR:  shade_rgb  = cfg_data[COLOR_W-1:0];
                    REG_ACCENT_COLOR: accent_rgb = cfg_data[COLOR_W-1:0];
                    default:          ;
                endcase
            end

            pending_writes = expected_writes.size();
        end
    end

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps

module tb;

    import scgb_pkg::*;

    localparam int LIMIT_CYCLES = 1000000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 24;

    localparam logic [PLANE_W-1:0]   PLANE_ACCENT = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE    = 3'd7;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0]      cfg_index = '0;
    logic [CFG_W-1:0]          cfg_data = '0;
    logic                      in_valid = 1'b0;
    logic                      in_ready;
    logic signed [COORD_W-1:0] glyph_left = '0;
    logic signed [COORD_W-1:0] glyph_top = '0;
    logic [GLYPH_W-1:0]        column = '0;
    logic [GLYPH_W-1:0]        row_index = '0;
    logic [ZOOM_IN_W-1:0]      zoom = '0;
    logic [PLANE_W-1:0]        plane = '0;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic [PIX_W-1:0]          pixel_x;
    logic [PIX_W-1:0]          pixel_y;
    logic [OFS_W-1:0]          byte_offset;
    logic [VAL_W-1:0]          pixel_value;
    logic                      last;

    int mismatch_count;
    int pending_writes;
    int cycle_count = 0;
    int cur_width = 320;
    int cur_height = 240;
    bit src_burst = 1'b0;
    bit sink_burst = 1'b0;
    bit hold_request = 1'b0;

    scaled_glyph_pixel_blitter u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .glyph_left  (glyph_left),
        .glyph_top   (glyph_top),
        .column      (column),
        .row_index   (row_index),
        .zoom        (zoom),
        .plane       (plane),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .pixel_x     (pixel_x),
        .pixel_y     (pixel_y),
        .byte_offset (byte_offset),
        .pixel_value (pixel_value),
        .last        (last)
    );

    scgb_blit_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write      (cfg_write),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .glyph_left     (glyph_left),
        .glyph_top      (glyph_top),
        .column         (column),
        .row_index      (row_index),
        .zoom           (zoom),
        .plane          (plane),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pixel_x        (pixel_x),
        .pixel_y        (pixel_y),
        .byte_offset    (byte_offset),
        .pixel_value    (pixel_value),
        .last           (last),
        .mismatch_count (mismatch_count),
        .pending_writes (pending_writes)
    );

    // 2 ns clock
    initial
    begin
        forever #1 clk = ~clk;
    end

    // watchdog
    initial
    begin
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    // register write; cfg_write is dropped again before the task returns
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == REG_FRAME_WIDTH)
            cur_width = 32'(data[PIX_W-1:0]);
        if (idx == REG_FRAME_HEIGHT)
            cur_height = 32'(data[PIX_W-1:0]);
        @(negedge clk);
        cfg_write <= 1'b0;
        @(negedge clk);
    endtask

    task automatic program_frame(
        input logic [PIX_W-1:0]   w,
        input logic [PIX_W-1:0]   h,
        input logic [FMT_W-1:0]   fmt,
        input logic [MASK_W-1:0]  mask,
        input logic [COLOR_W-1:0] ink,
        input logic [COLOR_W-1:0] shade,
        input logic [COLOR_W-1:0] accent
    );
        write_reg(REG_FRAME_WIDTH, CFG_W'(w));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(h));
        write_reg(REG_PIXEL_FORMAT, CFG_W'(fmt));
        write_reg(REG_PLANE_MASK, CFG_W'(mask));
        write_reg(REG_INK_COLOR, ink);
        write_reg(REG_SHADE_COLOR, shade);
        write_reg(REG_ACCENT_COLOR, accent);
    endtask

    // one pixel transfer; called and returns at a falling edge
    task automatic send_pixel(
        input logic [COORD_W-1:0]   left,
        input logic [COORD_W-1:0]   top,
        input logic [GLYPH_W-1:0]   col,
        input logic [GLYPH_W-1:0]   row,
        input logic [ZOOM_IN_W-1:0] zm,
        input logic [PLANE_W-1:0]   pl
    );
        int gap;
        gap = src_burst ? 0 : int'($urandom_range(0, 15));
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        glyph_left <= left;
        glyph_top  <= top;
        column     <= col;
        row_index  <= row;
        zoom       <= zm;
        plane      <= pl;
        in_valid   <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        @(negedge clk);
    endtask

    // drop valid, let every predicted write drain, then let empty items finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_writes != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // mostly pixels that land on or near the frame, some anywhere
    task automatic random_pixels(input int count);
        int                   k;
        int                   zc;
        int                   col;
        int                   row;
        int                   tx;
        int                   ty;
        logic [ZOOM_IN_W-1:0] zm;
        logic [PLANE_W-1:0]   pl;
        for (k = 0; k < count; k++)
        begin
            if (k % 24 == 0)
                src_burst = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 7))
                0:       zm = ZOOM_IN_W'($urandom);
                1:       zm = '0;
                default: zm = ZOOM_IN_W'($urandom_range(1, MAX_ZOOM));
            endcase
            if (zm == '0)
                zc = 1;
            else if (32'(zm) > MAX_ZOOM)
                zc = MAX_ZOOM;
            else
                zc = 32'(zm);
            if ($urandom_range(0, 7) == 0)
                pl = PLANE_CLEAR;
            else
                pl = PLANE_W'($urandom_range(1, 3));
            col = int'($urandom_range(0, 63));
            row = int'($urandom_range(0, 63));
            if ($urandom_range(0, 7) == 0)
            begin
                send_pixel(COORD_W'($urandom), COORD_W'($urandom), GLYPH_W'(col),
                           GLYPH_W'(row), zm, pl);
            end
            else
            begin
                tx = int'($urandom_range(0, cur_width + 7)) - 4;
                ty = int'($urandom_range(0, cur_height + 7)) - 4;
                send_pixel(COORD_W'(tx - col * zc), COORD_W'(ty - row * zc), GLYPH_W'(col),
                           GLYPH_W'(row), zm, pl);
            end
        end
        src_burst = 1'b0;
    endtask

    // stall the write side for a long stretch while pixels keep coming
    task automatic flood_while_held(input int count);
        int k;
        int cx;
        int cy;
        hold_request = 1'b1;
        src_burst = 1'b1;
        for (k = 0; k < count; k++)
        begin
            cx = int'($urandom_range(0, cur_width - MAX_ZOOM));
            cy = int'($urandom_range(0, cur_height - MAX_ZOOM));
            send_pixel(COORD_W'(cx), COORD_W'(cy), '0, '0, ZOOM_IN_W'(MAX_ZOOM), PLANE_INK);
        end
        src_burst = 1'b0;
    endtask

    // write side: random stall per write, bursts without stalls, one long hold
    initial
    begin : sink_side
        int stall;
        int taken;
        taken = 0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (taken % 40 == 0)
                sink_burst = ($urandom_range(0, 3) == 0);
            if (hold_request)
            begin
                stall = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else if (sink_burst)
                stall = 0;
            else
                stall = int'($urandom_range(0, 15));
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            taken++;
            @(negedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin : stimulus
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset surface: 320x240 rgb565, planes 1..3 drawn
        send_pixel(16'sd10, 16'sd10, 6'd0, 6'd0, 8'd1, PLANE_CLEAR);
        send_pixel(16'sd10, 16'sd10, 6'd1, 6'd2, 8'd1, PLANE_INK);
        send_pixel(16'sd0, 16'sd0, 6'd0, 6'd0, 8'd2, PLANE_SHADE);
        send_pixel(16'sd100, 16'sd50, 6'd3, 6'd4, 8'd3, PLANE_ACCENT);
        // zoom of zero, and zooms above the maximum
        send_pixel(16'sd5, 16'sd5, 6'd0, 6'd0, 8'd0, PLANE_INK);
        send_pixel(16'sd40, -16'sd100, 6'd63, 6'd63, 8'd255, PLANE_SHADE);
        send_pixel(16'sd200, 16'sd100, 6'd1, 6'd1, 8'd5, PLANE_ACCENT);
        // far glyph corner below the frame: fully clipped
        send_pixel(16'sd0, 16'sd0, 6'd63, 6'd63, 8'd4, PLANE_INK);
        // partial clips on each edge
        send_pixel(-16'sd2, 16'sd20, 6'd0, 6'd0, 8'd4, PLANE_INK);
        send_pixel(16'sd318, 16'sd20, 6'd0, 6'd0, 8'd4, PLANE_SHADE);
        send_pixel(16'sd20, -16'sd2, 6'd0, 6'd0, 8'd4, PLANE_ACCENT);
        send_pixel(16'sd20, 16'sd238, 6'd0, 6'd0, 8'd4, PLANE_INK);
        send_pixel(16'sd319, 16'sd239, 6'd0, 6'd0, 8'd1, PLANE_SHADE);
        send_pixel(16'sd319, 16'sd239, 6'd0, 6'd0, 8'd4, PLANE_INK);
        // most negative corner
        send_pixel(16'sh8000, 16'sh8000, 6'd63, 6'd63, 8'd4, PLANE_INK);
        // span end wrapping past the top of the 16-bit range
        send_pixel(16'sh7fff, 16'sd0, 6'd0, 6'd0, 8'd4, PLANE_INK);
        send_pixel(16'sh7ffd, 16'sd0, 6'd0, 6'd0, 8'd4, PLANE_SHADE);
        send_pixel(16'sh7fff, 16'sd0, 6'd63, 6'd0, 8'd4, PLANE_ACCENT);
        send_pixel(16'sd0, 16'sh7fff, 6'd0, 6'd1, 8'd4, PLANE_INK);
        send_pixel(-16'sd300, 16'sd0, 6'd63, 6'd0, 8'd4, PLANE_INK);
        send_pixel(16'sd0, 16'sd0, 6'd63, 6'd0, 8'd1, PLANE_ACCENT);
        send_pixel(16'sd0, 16'sd0, 6'd0, 6'd63, 8'd2, PLANE_CLEAR);
        random_pixels(80);
        wait_idle();

        // small rgba surface, every plane bit set; the spare index is ignored
        program_frame(12'd64, 12'd48, FMT_RGBA8888, 4'hf, 24'h123456, 24'hff0000, 24'h00ff00);
        write_reg(REG_SPARE, 24'hffffff);
        send_pixel(16'sd10, 16'sd10, 6'd0, 6'd0, 8'd2, PLANE_CLEAR);
        random_pixels(70);
        wait_idle();

        // largest surface in rgba, so byte offsets run near the top of the 26-bit field; only ink drawn
        program_frame(12'd4095, 12'd4095, FMT_RGBA8888, 4'h2, 24'h000000, 24'hffffff,
                      24'h808080);
        send_pixel(16'sd100, 16'sd100, 6'd0, 6'd0, 8'd2, PLANE_SHADE);
        send_pixel(16'sd100, 16'sd100, 6'd0, 6'd0, 8'd2, PLANE_ACCENT);
        send_pixel(16'sd4092, 16'sd4092, 6'd0, 6'd0, 8'd4, PLANE_INK);
        random_pixels(70);
        flood_while_held(30);
        wait_idle();

        // single-pixel surface, only the accent plane
        program_frame(12'd1, 12'd1, FMT_RGBA8888, 4'h8, 24'hffffff, 24'h000000,
                      COLOR_W'($urandom));
        random_pixels(40);
        wait_idle();

        // zero width, then zero height: everything is clipped
        program_frame(12'd0, 12'd100, FMT_RGB565, 4'hf, 24'hffffff, 24'hffffff, 24'hffffff);
        random_pixels(15);
        wait_idle();
        write_reg(REG_FRAME_WIDTH, CFG_W'(100));
        write_reg(REG_FRAME_HEIGHT, CFG_W'(0));
        random_pixels(15);
        wait_idle();

        // odd small surface with random colors
        program_frame(12'd17, 12'd9, FMT_RGB565, 4'he, COLOR_W'($urandom), COLOR_W'($urandom),
                      COLOR_W'($urandom));
        random_pixels(50);
        wait_idle();

        // default size, shade plane only
        program_frame(12'd320, 12'd240, FMT_RGB565, 4'h4, COLOR_W'($urandom),
                      COLOR_W'($urandom), COLOR_W'($urandom));
        random_pixels(50);
        wait_idle();

        // wide single row
        program_frame(12'd2047, 12'd1, FMT_RGBA8888, 4'h6, COLOR_W'($urandom),
                      COLOR_W'($urandom), COLOR_W'($urandom));
        random_pixels(40);
        wait_idle();

        if (mismatch_count == 0 && pending_writes == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

[files.f]
src/scgb_pkg.sv
src/scaled_glyph_pixel_blitter.sv
tb/scgb_blit_checker.sv
tb/tb.sv
